// ===== hw/rtl/rac_pkg.sv =====
// rac_pkg: shared types and codes for the rational accumulator
// no dependencies; imported by rac_unit and rational_accumulator
package rac_pkg;

  localparam int FIELD_WIDTH         = 32;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // operation codes carried by an input transaction
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_MUL  = 2'd2
  } op_t;

  // function select of the shared adder
  typedef enum logic {
    UNIT_ADD = 1'b0,
    UNIT_SUB = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic [1:0]                    operation;
    logic signed [FIELD_WIDTH-1:0] operand_numerator;
    logic signed [FIELD_WIDTH-1:0] operand_denominator;
  } operand_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] result_numerator;
    logic signed [FIELD_WIDTH-1:0] result_denominator;
  } result_t;

endpackage

// ===== hw/rtl/rac_unit.sv =====
// rac_unit: shared add/subtract unit with carry out
// depends on rac_pkg
module rac_unit #(
  parameter int VALUE_WIDTH = rac_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  input  rac_pkg::unit_op_t      op,
  output logic [VALUE_WIDTH-1:0] res,
  output logic                   carry
);
  import rac_pkg::*;

  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH-1:0] b_sel;
  logic                   is_sub;

  assign is_sub = (op == UNIT_SUB);
  assign b_sel  = is_sub ? ~b : b;
  // for subtract, carry high means no borrow (a >= b)
  assign sum    = {1'b0, a} + {1'b0, b_sel} + (VALUE_WIDTH + 1)'(is_sub);
  assign res    = sum[VALUE_WIDTH-1:0];
  assign carry  = sum[VALUE_WIDTH];

endmodule

// ===== hw/rtl/rational_accumulator.sv =====
// rational_accumulator: running fraction with load, add, multiply and gcd reduction
// depends on rac_pkg and rac_unit
// steps, from the accepting edge: load and unused codes go straight to the output
//   register; multiply runs two shift-add products, add runs three products and
//   one sum; a reduction, when both results are positive, adds a binary gcd and
//   two restoring divisions; each result then waits for the output register
// throughput: one transaction at a time, set by the one shared adder that every
//   multiply bit, gcd subtract and division bit goes through
// reset: synchronous; the fraction returns to 0/1 and no result is pending
module rational_accumulator #(
  parameter int VALUE_WIDTH = rac_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              operand_valid,
  output logic              operand_ready,
  input  rac_pkg::operand_t operand,
  output logic              result_valid,
  input  logic              result_ready,
  output rac_pkg::result_t  result
);
  import rac_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_DONE,
    ST_SUM,
    ST_CHECK,
    ST_TWOS,
    ST_AODD,
    ST_LOOP,
    ST_SHIFT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_EMIT
  } state_t;

  state_t state;

  // stored fraction
  logic [W-1:0] n;
  logic [W-1:0] d;
  // current transaction
  logic [1:0]   op;
  logic [W-1:0] on;
  logic [W-1:0] od;
  // fraction under construction
  logic [W-1:0] nn;
  logic [W-1:0] nd;
  logic [W-1:0] t;
  // shift-add multiplier
  logic [W-1:0] acc;
  logic [W-1:0] mc;
  logic [W-1:0] mp;
  // binary gcd
  logic [W-1:0] ga;
  logic [W-1:0] gb;
  // restoring divider
  logic [W-1:0] r;
  logic [W-1:0] q;
  logic [W-1:0] rs;
  // sequencing
  logic [1:0]       ph;
  logic [CNT_W-1:0] cnt;

  // shared unit hookup
  logic [W-1:0] ua;
  logic [W-1:0] ub;
  unit_op_t     uop;
  logic [W-1:0] ures;
  logic         ucarry;

  logic [W-1:0] won;
  logic [W-1:0] wod;
  logic         both_pos;
  logic         cnt_last;
  logic         emit_fire;

  rac_unit #(
    .VALUE_WIDTH(W)
  ) u_unit (
    .a    (ua),
    .b    (ub),
    .op   (uop),
    .res  (ures),
    .carry(ucarry)
  );

  // operands sign-extended from the field, then wrapped to the value width
  assign won = W'(operand.operand_numerator);
  assign wod = W'(operand.operand_denominator);

  // next remainder before the trial subtract
  assign rs = {r[W-2:0], q[W-1]};

  assign both_pos  = (nn != '0) && !nn[W-1] && (nd != '0) && !nd[W-1];
  assign cnt_last  = (cnt == CNT_W'(W - 1));
  assign emit_fire = (state == ST_EMIT) && (!result_valid || result_ready);

  assign operand_ready = (state == ST_IDLE);

  // operand select for the shared unit
  always_comb begin
    ua  = acc;
    ub  = mc;
    uop = UNIT_ADD;
    unique case (state)
      ST_MUL_RUN: begin
        ua  = acc;
        ub  = mc;
        uop = UNIT_ADD;
      end
      ST_SUM: begin
        ua  = t;
        ub  = acc;
        uop = UNIT_ADD;
      end
      ST_LOOP: begin
        ua  = gb;
        ub  = ga;
        uop = UNIT_SUB;
      end
      ST_DIV_RUN: begin
        ua  = rs;
        ub  = ga;
        uop = UNIT_SUB;
      end
      default: begin
        ua  = acc;
        ub  = mc;
        uop = UNIT_ADD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      n            <= '0;
      d            <= W'(1);
    end else begin
      // output slot drains independently of the sequencer, unless refilled now
      if (result_valid && result_ready && !emit_fire) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (operand_valid) begin
            op <= operand.operation;
            on <= won;
            od <= wod;
            ph <= 2'd0;
            unique case (operand.operation) inside
              OP_LOAD: begin
                nn    <= won;
                nd    <= wod;
                state <= ST_EMIT;
              end
              OP_ADD, OP_MUL: begin
                state <= ST_MUL_LOAD;
              end
              default: begin
                // unused code keeps the fraction
                nn    <= n;
                nd    <= d;
                state <= ST_EMIT;
              end
            endcase
          end
        end

        ST_MUL_LOAD: begin
          acc <= '0;
          cnt <= '0;
          if (op == OP_ADD) begin
            // n*od, then d*on, then d*od
            mc <= (ph == 2'd0) ? n : d;
            mp <= (ph == 2'd1) ? on : od;
          end else begin
            // n*on, then d*od
            mc <= (ph == 2'd0) ? n : d;
            mp <= (ph == 2'd0) ? on : od;
          end
          state <= ST_MUL_RUN;
        end

        ST_MUL_RUN: begin
          if (mp[0]) begin
            acc <= ures;
          end
          mc  <= {mc[W-2:0], 1'b0};
          mp  <= {1'b0, mp[W-1:1]};
          cnt <= cnt + CNT_W'(1);
          if (cnt_last) begin
            state <= ST_MUL_DONE;
          end
        end

        ST_MUL_DONE: begin
          if (op == OP_ADD) begin
            if (ph == 2'd0) begin
              t     <= acc;
              ph    <= 2'd1;
              state <= ST_MUL_LOAD;
            end else if (ph == 2'd1) begin
              state <= ST_SUM;
            end else begin
              nd    <= acc;
              state <= ST_CHECK;
            end
          end else begin
            if (ph == 2'd0) begin
              nn    <= acc;
              ph    <= 2'd1;
              state <= ST_MUL_LOAD;
            end else begin
              nd    <= acc;
              state <= ST_CHECK;
            end
          end
        end

        ST_SUM: begin
          nn    <= ures;
          ph    <= 2'd2;
          state <= ST_MUL_LOAD;
        end

        ST_CHECK: begin
          if (both_pos) begin
            ga    <= nn;
            gb    <= nd;
            cnt   <= '0;
            state <= ST_TWOS;
          end else begin
            state <= ST_EMIT;
          end
        end

        // strip common factors of two, counted in cnt
        ST_TWOS: begin
          if (!ga[0] && !gb[0]) begin
            ga  <= {1'b0, ga[W-1:1]};
            gb  <= {1'b0, gb[W-1:1]};
            cnt <= cnt + CNT_W'(1);
          end else begin
            state <= ST_AODD;
          end
        end

        ST_AODD: begin
          if (!ga[0]) begin
            ga <= {1'b0, ga[W-1:1]};
          end else begin
            state <= ST_LOOP;
          end
        end

        // ga stays odd; gb is halved, swapped with ga when smaller, or reduced by ga until zero
        ST_LOOP: begin
          if (gb == '0) begin
            state <= ST_SHIFT;
          end else if (!gb[0]) begin
            gb <= {1'b0, gb[W-1:1]};
          end else if (!ucarry) begin
            ga <= gb;
            gb <= ga;
          end else begin
            gb <= ures;
          end
        end

        // restore the common power of two
        ST_SHIFT: begin
          if (cnt != '0) begin
            ga  <= {ga[W-2:0], 1'b0};
            cnt <= cnt - CNT_W'(1);
          end else begin
            ph    <= 2'd0;
            state <= ST_DIV_LOAD;
          end
        end

        ST_DIV_LOAD: begin
          r     <= '0;
          q     <= (ph == 2'd0) ? nn : nd;
          cnt   <= '0;
          state <= ST_DIV_RUN;
        end

        ST_DIV_RUN: begin
          r   <= ucarry ? ures : rs;
          q   <= {q[W-2:0], ucarry};
          cnt <= cnt + CNT_W'(1);
          if (cnt_last) begin
            state <= ST_DIV_DONE;
          end
        end

        ST_DIV_DONE: begin
          if (ph == 2'd0) begin
            nn    <= q;
            ph    <= 2'd1;
            state <= ST_DIV_LOAD;
          end else begin
            nd    <= q;
            state <= ST_EMIT;
          end
        end

        // commit and publish once the output slot is free
        ST_EMIT: begin
          if (emit_fire) begin
            n                         <= nn;
            d                         <= nd;
            result.result_numerator   <= FIELD_WIDTH'(nn);
            result.result_denominator <= FIELD_WIDTH'(nd);
            result_valid              <= 1'b1;
            state                     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // gcd loop invariant: the kept operand is odd
  a_gcd_odd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOP) |-> ga[0])
    else $error("gcd operand lost its odd value");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_RUN) |-> (r < ga))
    else $error("division remainder reached the divisor");

  // a committed fraction always reaches the output register
  a_emit: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (result_valid && (state == ST_IDLE)))
    else $error("commit did not publish a result");

  // the sequencer never leaves idle without a transaction
  a_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && !operand_valid) |=> (state == ST_IDLE))
    else $error("sequencer started without a transaction");

endmodule
